// File: sv/srd_pkg.sv
// Shared types and constants for the run-length sprite decoder.
// No dependencies; the front end, op queue, back end and top level import this package.
package srd_pkg;

	localparam int MAX_SIDE_DEF = 4096;

	localparam int XW = 13;
	localparam int RW = 12;
	localparam int BW = 8;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes
	localparam logic [1:0] REG_REFLECT    = 2'd0;
	localparam logic [1:0] REG_WIDTH      = 2'd1;
	localparam logic [1:0] REG_SHADOW_EN  = 2'd2;

	// Stream codes
	localparam logic [7:0] CODE_NEWLINE = 8'h00;
	localparam logic [7:0] CODE_END     = 8'h80;
	localparam logic [7:0] CODE_SHADOW  = 8'hC0;
	localparam logic [7:0] CODE_C1      = 8'hC1;

	// Result kinds and status values
	localparam logic [1:0] KIND_COLOR  = 2'd0;
	localparam logic [1:0] KIND_SHADOW = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_END = 2'd1;
	localparam logic [1:0] ST_EOB = 2'd2;

	typedef enum logic [6:0] {
		PH_CMD    = 7'b0000001,
		PH_LIT    = 7'b0000010,
		PH_SH1    = 7'b0000100,
		PH_SH2    = 7'b0001000,
		PH_C1CNT  = 7'b0010000,
		PH_C1COL  = 7'b0100000,
		PH_REPCOL = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		OP_NOP     = 3'd0,
		OP_NEWLINE = 3'd1,
		OP_SKIP    = 3'd2,
		OP_COLOR   = 3'd3,
		OP_SHADOW  = 3'd4
	} op_code_t;

	// One decoded command for the back end
	typedef struct packed {
		logic            restart;
		op_code_t        code;
		logic [BW-1:0]   len;
		logic [BW-1:0]   color;
		logic [1:0]      status;
	} op_t;

endpackage

// File: sv/srd_in_if.sv
// Byte stream channel of the sprite decoder.
// Depends on nothing; fields follow the encoded stream byte layout.
interface srd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_image;
	logic       end_of_buffer;

	modport source(output valid, data_byte, first_of_image, end_of_buffer, input ready);
	modport sink(input valid, data_byte, first_of_image, end_of_buffer, output ready);
endinterface

// File: sv/srd_out_if.sv
// Run result channel of the sprite decoder.
// Depends on nothing; one beat carries one run or end marker.
interface srd_out_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] run_start_x;
	logic [11:0]        run_row;
	logic [7:0]         run_length;
	logic [1:0]         run_kind;
	logic [7:0]         color_index;
	logic [1:0]         end_status;
	logic               last;

	modport source(output valid, run_start_x, run_row, run_length, run_kind, color_index,
		end_status, last, input ready);
	modport sink(input valid, run_start_x, run_row, run_length, run_kind, color_index,
		end_status, last, output ready);
endinterface

// File: sv/srd_cfg_if.sv
// Configuration write channel of the sprite decoder.
// Depends on nothing; index selects reflect, image width or shadow enable.
interface srd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/srd_front.sv
// Front end: accepts stream bytes, tracks the command phase and emits decoded ops.
// Depends on srd_pkg and srd_in_if.
module srd_front (
	input  logic          clk,
	input  logic          arst_n,
	srd_in_if.sink        stream,
	output logic          push,
	output srd_pkg::op_t  push_op,
	input  logic          full
);
	import srd_pkg::*;

	phase_t        phase_q, ph, nxt_phase;
	logic [BW-1:0] pend_q, pend, nxt_pend;
	logic          done_q, done, nxt_done;
	logic [BW-1:0] b;
	logic          accept;
	op_t           op;

	assign b            = stream.data_byte;
	assign stream.ready = !full;
	assign accept       = stream.valid && !full;

	always_comb begin
		ph   = stream.first_of_image ? PH_CMD : phase_q;
		pend = stream.first_of_image ? '0 : pend_q;
		done = stream.first_of_image ? 1'b0 : done_q;

		op.restart = stream.first_of_image;
		op.code    = OP_NOP;
		op.len     = '0;
		op.color   = '0;
		op.status  = stream.end_of_buffer ? ST_EOB : ST_RUN;
		nxt_phase  = ph;
		nxt_pend   = pend;
		nxt_done   = done;

		unique case (ph)
			PH_CMD: begin
				if (b == CODE_NEWLINE) begin
					op.code = OP_NEWLINE;
				end else if (b < CODE_END) begin
					nxt_pend  = b;
					nxt_phase = PH_LIT;
				end else if (b == CODE_END) begin
					op.status = ST_END;
				end else if (b < CODE_SHADOW) begin
					op.code = OP_SKIP;
					op.len  = b - CODE_END;
				end else if (b == CODE_SHADOW) begin
					nxt_phase = PH_SH1;
				end else if (b == CODE_C1) begin
					nxt_phase = PH_C1CNT;
				end else begin
					nxt_pend  = b - CODE_SHADOW;
					nxt_phase = PH_REPCOL;
				end
			end
			PH_LIT: begin
				op.code  = OP_COLOR;
				op.len   = BW'(1);
				op.color = b;
				nxt_pend = pend - BW'(1);
				if (nxt_pend == '0) begin
					nxt_phase = PH_CMD;
				end
			end
			PH_SH1: begin
				if (b[1:0] == 2'd0) begin
					nxt_phase = PH_SH2;
				end else begin
					op.code   = OP_SHADOW;
					op.len    = {{(BW-2){1'b0}}, b[1:0]};
					nxt_phase = PH_CMD;
				end
			end
			PH_SH2: begin
				op.code   = OP_SHADOW;
				op.len    = b;
				nxt_phase = PH_CMD;
			end
			PH_C1CNT: begin
				nxt_pend  = b;
				nxt_phase = PH_C1COL;
			end
			PH_C1COL, PH_REPCOL: begin
				// zero count draws nothing
				if (pend != '0) begin
					op.code  = OP_COLOR;
					op.len   = pend;
					op.color = b;
				end
				nxt_pend  = '0;
				nxt_phase = PH_CMD;
			end
			default: begin
				nxt_phase = PH_CMD;
			end
		endcase

		if (op.status != ST_RUN) begin
			nxt_done  = 1'b1;
			nxt_phase = PH_CMD;
			nxt_pend  = '0;
		end

		// hold state and drop bytes once the image has ended
		if (done) begin
			nxt_phase = phase_q;
			nxt_pend  = pend_q;
			nxt_done  = done_q;
		end
	end

	assign push_op = op;
	assign push    = accept && !done
		&& (op.code != OP_NOP || op.restart || op.status != ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			pend_q  <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			pend_q  <= nxt_pend;
			done_q  <= nxt_done;
		end
	end

endmodule

// File: sv/srd_fifo.sv
// Short op queue between the decoder front and back ends.
// Depends on srd_pkg for the op type and depth.
module srd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  srd_pkg::op_t  wdata,
	output logic          full,
	input  logic          pop,
	output srd_pkg::op_t  rdata,
	output logic          empty
);
	import srd_pkg::*;

	op_t                mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] count_q;

	assign full  = count_q == FIFO_CW'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

endmodule

// File: sv/srd_back.sv
// Back end: holds the cursor and configuration, executes ops and drives run beats.
// Depends on srd_pkg, srd_out_if and srd_cfg_if.
module srd_back #(
	parameter int MAX_SIDE = srd_pkg::MAX_SIDE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	srd_cfg_if.sink       cfg,
	srd_out_if.source     runs,
	input  srd_pkg::op_t  op,
	input  logic          empty,
	output logic          pop
);
	import srd_pkg::*;

	logic          reflect_q, shadow_en_q;
	logic [XW-1:0] width_q;
	logic [XW-1:0] cursor_x_q;
	logic [RW-1:0] cursor_row_q;

	logic [XW-1:0] w_eff, line_start, x0, x1, moved, len_x;
	logic [RW-1:0] row0, row1;
	logic          is_run, emit;

	assign cfg.ready = 1'b1;

	always_comb begin
		w_eff      = (32'(width_q) > MAX_SIDE) ? XW'(MAX_SIDE) : width_q;
		line_start = reflect_q ? w_eff - XW'(1) : '0;
		x0         = op.restart ? line_start : cursor_x_q;
		row0       = op.restart ? '0 : cursor_row_q;
		len_x      = {{(XW-BW){1'b0}}, op.len};
		moved      = reflect_q ? x0 - len_x : x0 + len_x;
		x1         = x0;
		row1       = row0;
		unique case (op.code) inside
			OP_NEWLINE: begin
				x1   = line_start;
				row1 = row0 + RW'(1);
			end
			OP_SKIP, OP_COLOR, OP_SHADOW: begin
				x1 = moved;
			end
			default: begin
				x1 = x0;
			end
		endcase
		is_run = (op.code == OP_COLOR)
			|| (op.code == OP_SHADOW && shadow_en_q && op.len != '0);
		emit   = is_run || op.status != ST_RUN;
	end

	// advance when the output register is free or drains this cycle
	assign pop = !empty && (!runs.valid || runs.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reflect_q    <= 1'b0;
			width_q      <= XW'(1);
			shadow_en_q  <= 1'b1;
			cursor_x_q   <= '0;
			cursor_row_q <= '0;
			runs.valid   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_REFLECT:   reflect_q   <= cfg.data[0];
					REG_WIDTH:     width_q     <= cfg.data;
					REG_SHADOW_EN: shadow_en_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
			if (pop) begin
				cursor_x_q   <= x1;
				cursor_row_q <= row1;
				runs.valid   <= emit;
			end else if (runs.ready) begin
				runs.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			runs.run_start_x <= is_run ? x0 : x1;
			runs.run_row     <= is_run ? row0 : row1;
			runs.run_length  <= is_run ? op.len : '0;
			runs.run_kind    <= !is_run ? KIND_END
				: (op.code == OP_SHADOW) ? KIND_SHADOW : KIND_COLOR;
			runs.color_index <= (is_run && op.code == OP_COLOR) ? op.color : '0;
			runs.end_status  <= op.status;
			runs.last        <= op.status != ST_RUN;
		end
	end

endmodule

// File: sv/sprite_rle_run_decoder.sv
// Run-length sprite decoder top level: front end, op queue, back end.
// Depends on srd_pkg, the channel interfaces, srd_front, srd_fifo and srd_back.
//
//  channel  role    beat
//  stream   sink    data_byte, first_of_image, end_of_buffer
//  runs     source  run_start_x, run_row, run_length, run_kind, color_index,
//                   end_status, last
//  cfg      sink    index, data (0 reflect, 1 image width, 2 shadow enable)
//
// One byte per cycle is accepted while the two-entry op queue has room.
// A byte's run reaches the runs register through the op queue: the front end
// decodes the byte into the queue as it is taken, and the back end updates the
// cursor and loads the register when it pops that op, which a stall can delay.
// A stalled runs channel holds the back end; the queue then fills and stream
// ready drops. The cfg channel is always ready. Reset clears cursor and phase.
module sprite_rle_run_decoder #(
	parameter int MAX_SIDE = srd_pkg::MAX_SIDE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srd_in_if.sink    stream,
	srd_out_if.source runs,
	srd_cfg_if.sink   cfg
);
	import srd_pkg::*;

	logic push, pop, full, empty;
	op_t  push_op, pop_op;

	srd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.push    (push),
		.push_op (push_op),
		.full    (full)
	);

	srd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_op),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_op),
		.empty  (empty)
	);

	srd_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.runs   (runs),
		.op     (pop_op),
		.empty  (empty),
		.pop    (pop)
	);

endmodule
